@@ sv/clock_sync_interval_estimator_top_macros.svh @@
// Assertion macros for the clock sync interval estimator.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef CLOCK_SYNC_INTERVAL_ESTIMATOR_TOP_MACROS_SVH
`define CLOCK_SYNC_INTERVAL_ESTIMATOR_TOP_MACROS_SVH

// check a property on every clock edge outside reset
`define CSIE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check that a condition is followed by another in the next cycle
`define CSIE_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

@@ sv/csie_pkg.sv @@
// Shared types, constants and helpers for the clock sync interval estimator.
// No dependencies; used by csie_drift_div and the top level.
package csie_pkg;

  localparam int unsigned QuotW = 24;
  localparam int unsigned PreShift = 8;
  localparam logic signed [QuotW-1:0] DriftMax = 24'sh7FFFFF;
  localparam logic signed [QuotW-1:0] DriftMin = 24'sh800000;
  localparam logic [QuotW-1:0] NegLimit = 24'h800000;
  localparam logic [QuotW-1:0] PosLimit = 24'h7FFFFF;

  localparam logic KindSync = 1'b0;
  localparam logic KindQuery = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_Q1,
    ST_Q2,
    ST_S1,
    ST_S2,
    ST_S3,
    ST_S4,
    ST_S5,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    D_IDLE,
    D_CHECK,
    D_ITER,
    D_FIN
  } div_state_e;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                    busy;
    logic                    done;
    logic signed [QuotW-1:0] quot;
  } div_rsp_t;

  // signed wrapped difference a - b, halved toward zero
  function automatic logic [31:0] half_diff(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    logic [31:0] s;
    d = a - b;
    s = d + {31'd0, d[31]};
    return {s[31], s[31:1]};
  endfunction

endpackage

@@ sv/csie_drift_div.sv @@
// Bit-serial divider for drift: shift * 65536 / elapsed, Q7.16, saturated.
// One quotient bit per cycle; depends on csie_pkg.
module csie_drift_div import csie_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int unsigned CntW = $clog2(QuotW);
  localparam logic [CntW-1:0] LastCnt = CntW'(QuotW - 1);

  div_state_e       state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             sign_q, sign_d;
  logic             sat_q, sat_d;
  logic [31:0]      mag_q, mag_d;
  logic [31:0]      dsr_q, dsr_d;
  logic [31:0]      rem_q, rem_d;
  logic [QuotW-1:0] sh_q, sh_d;
  logic [31:0]      rem_sh;
  logic [31:0]      head;
  logic             ge;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q  <= cnt_d;
    sign_q <= sign_d;
    sat_q  <= sat_d;
    mag_q  <= mag_d;
    dsr_q  <= dsr_d;
    rem_q  <= rem_d;
    sh_q   <= sh_d;
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    sign_d  = sign_q;
    sat_d   = sat_q;
    mag_d   = mag_q;
    dsr_d   = dsr_q;
    rem_d   = rem_q;
    sh_d    = sh_q;
    head    = {PreShift'(0), mag_q[31:PreShift]};
    rem_sh  = {rem_q[30:0], sh_q[QuotW-1]};
    ge      = (rem_sh >= dsr_q);
    rsp_o.busy = (state_q != D_IDLE);
    rsp_o.done = 1'b0;
    rsp_o.quot = '0;
    unique case (state_q)
      D_IDLE: begin
        if (req_i.start) begin
          sign_d  = req_i.dividend[31];
          mag_d   = req_i.dividend[31] ? (32'd0 - req_i.dividend) : req_i.dividend;
          dsr_d   = req_i.divisor;
          state_d = D_CHECK;
        end
      end
      D_CHECK: begin
        cnt_d = '0;
        rem_d = head;
        sh_d  = {mag_q[PreShift-1:0], 16'd0};
        sat_d = (head >= dsr_q);
        state_d = (head >= dsr_q) ? D_FIN : D_ITER;
      end
      D_ITER: begin
        rem_d = ge ? (rem_sh - dsr_q) : rem_sh;
        sh_d  = {sh_q[QuotW-2:0], ge};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LastCnt) begin
          state_d = D_FIN;
        end
      end
      D_FIN: begin
        rsp_o.done = 1'b1;
        if (sign_q) begin
          rsp_o.quot = (sat_q || sh_q > NegLimit) ? DriftMin : $signed(QuotW'(0) - sh_q);
        end else begin
          rsp_o.quot = (sat_q || sh_q > PosLimit) ? DriftMax : $signed(sh_q);
        end
        state_d = D_IDLE;
      end
      default: state_d = D_IDLE;
    endcase
  end

endmodule

@@ sv/clock_sync_interval_estimator_top.sv @@
// Clock sync interval estimator: keeps a global-time interval from round-trip
// sync replies and answers time queries. A synced query runs ST_Q1 and ST_Q2; a
// sync runs ST_S1 up to ST_S5, then ST_DIV when the 24-step bit-serial divider
// in csie_drift_div computes drift. One item is in flight at a time; the input
// stalls until its result sits in the output register, which then waits for the
// sink. Depends on csie_pkg, csie_drift_div and the assertion macro header.
`include "clock_sync_interval_estimator_top_macros.svh"

module clock_sync_interval_estimator_top import csie_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               kind_i,
  input  logic [30:0]        local_now_i,
  input  logic [30:0]        request_sent_i,
  input  logic signed [31:0] global_reply_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               status_o,
  output logic [29:0]        half_lag_o,
  output logic signed [23:0] drift_q16_o,
  output logic signed [31:0] global_estimate_o
);

  state_e      state_q, state_d;
  logic        synced_q, synced_d;
  logic [31:0] elapsed_q, elapsed_d;
  logic [31:0] shift_q, shift_d;
  logic [31:0] last_q, last_d;
  logic [31:0] low_q, low_d;
  logic [31:0] high_q, high_d;
  logic        out_valid_q, out_valid_d;

  logic [30:0] now_q, now_d;
  logic [30:0] req_q, req_d;
  logic [31:0] glob_q, glob_d;
  logic [30:0] lag_q, lag_d;
  logic [31:0] top_q, top_d;
  logic [31:0] est_q, est_d;
  logic [31:0] step_q, step_d;
  logic [31:0] tmp_q, tmp_d;
  logic        res_status_q, res_status_d;
  logic [29:0] res_half_q, res_half_d;
  logic [23:0] res_drift_q, res_drift_d;
  logic [31:0] res_est_q, res_est_d;
  logic        st_q, st_d;
  logic [29:0] oh_q, oh_d;
  logic [23:0] od_q, od_d;
  logic [31:0] oe_q, oe_d;

  logic        accept;
  logic        reseed;
  logic [31:0] diff_nr;
  logic [31:0] mid;
  div_req_t    div_req;
  div_rsp_t    div_rsp;

  csie_drift_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign status_o          = st_q;
  assign half_lag_o        = oh_q;
  assign drift_q16_o       = $signed(od_q);
  assign global_estimate_o = $signed(oe_q);
  assign reseed = !synced_q || step_q[31];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      synced_q    <= 1'b0;
      elapsed_q   <= '0;
      shift_q     <= '0;
      last_q      <= '0;
      low_q       <= '0;
      high_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      synced_q    <= synced_d;
      elapsed_q   <= elapsed_d;
      shift_q     <= shift_d;
      last_q      <= last_d;
      low_q       <= low_d;
      high_q      <= high_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q        <= now_d;
    req_q        <= req_d;
    glob_q       <= glob_d;
    lag_q        <= lag_d;
    top_q        <= top_d;
    est_q        <= est_d;
    step_q       <= step_d;
    tmp_q        <= tmp_d;
    res_status_q <= res_status_d;
    res_half_q   <= res_half_d;
    res_drift_q  <= res_drift_d;
    res_est_q    <= res_est_d;
    st_q         <= st_d;
    oh_q         <= oh_d;
    od_q         <= od_d;
    oe_q         <= oe_d;
  end

  always_comb begin
    state_d      = state_q;
    synced_d     = synced_q;
    elapsed_d    = elapsed_q;
    shift_d      = shift_q;
    last_d       = last_q;
    low_d        = low_q;
    high_d       = high_q;
    out_valid_d  = out_valid_q && out_stall_i;
    now_d        = now_q;
    req_d        = req_q;
    glob_d       = glob_q;
    lag_d        = lag_q;
    top_d        = top_q;
    est_d        = est_q;
    step_d       = step_q;
    tmp_d        = tmp_q;
    res_status_d = res_status_q;
    res_half_d   = res_half_q;
    res_drift_d  = res_drift_q;
    res_est_d    = res_est_q;
    st_d         = st_q;
    oh_d         = oh_q;
    od_d         = od_q;
    oe_d         = oe_q;
    diff_nr      = {1'b0, now_q} - {1'b0, req_q};
    mid          = low_q + tmp_q;
    div_req.start    = 1'b0;
    div_req.dividend = shift_q;
    div_req.divisor  = elapsed_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          now_d        = local_now_i;
          req_d        = request_sent_i;
          glob_d       = global_reply_i;
          res_status_d = 1'b0;
          res_half_d   = '0;
          res_drift_d  = '0;
          res_est_d    = '0;
          if (kind_i == KindQuery) begin
            state_d = synced_q ? ST_Q1 : ST_DONE;
          end else begin
            state_d = ST_S1;
          end
        end
      end
      ST_Q1: begin
        tmp_d   = half_diff(high_q, low_q);
        state_d = ST_Q2;
      end
      ST_Q2: begin
        res_status_d = 1'b1;
        res_half_d   = tmp_q[31] ? '0 : tmp_q[29:0];
        res_est_d    = low_q + tmp_q + ({1'b0, now_q} - last_q);
        state_d      = ST_DONE;
      end
      ST_S1: begin
        lag_d  = diff_nr[30:0];
        top_d  = glob_q + {1'b0, diff_nr[30:0]};
        est_d  = glob_q + {2'b0, diff_nr[30:1]};
        step_d = {1'b0, now_q} - last_q;
        state_d = (now_q < req_q) ? ST_DONE : ST_S2;
      end
      ST_S2: begin
        res_status_d = 1'b1;
        res_half_d   = lag_q[30:1];
        last_d       = {1'b0, now_q};
        if (reseed) begin
          synced_d  = 1'b1;
          elapsed_d = '0;
          shift_d   = '0;
          low_d     = glob_q;
          high_d    = top_q;
          state_d   = ST_DONE;
        end else begin
          low_d     = low_q + step_q;
          high_d    = high_q + step_q;
          elapsed_d = elapsed_q + step_q;
          state_d   = ST_S3;
        end
      end
      ST_S3: begin
        tmp_d   = half_diff(high_q, low_q);
        state_d = ST_S4;
      end
      ST_S4: begin
        shift_d = shift_q + (est_q - mid);
        if ($signed(est_q) < $signed(low_q) || $signed(est_q) > $signed(high_q)) begin
          low_d  = glob_q;
          high_d = top_q;
        end else begin
          if ($signed(glob_q) > $signed(low_q)) begin
            low_d = glob_q;
          end
          if ($signed(top_q) < $signed(high_q)) begin
            high_d = top_q;
          end
        end
        state_d = ST_S5;
      end
      ST_S5: begin
        if (shift_q != '0 && !elapsed_q[31] && elapsed_q != '0) begin
          div_req.start = 1'b1;
          state_d       = ST_DIV;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          res_drift_d = div_rsp.quot;
          state_d     = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          st_d        = res_status_q;
          oh_d        = res_half_q;
          od_d        = res_drift_q;
          oe_d        = res_est_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  `CSIE_ASSERT(a_div_in_div_state, !div_rsp.busy || state_q == ST_DIV, "divider busy early")
  `CSIE_ASSERT(a_status_sync, !res_status_q || state_q != ST_DONE || synced_q, "not synced")
  `CSIE_ASSERT_NEXT(a_reseed_clears, state_q == ST_S2 && reseed, (elapsed_q | shift_q) == '0, "totals")
  `CSIE_ASSERT(a_synced_holds, !$fell(synced_q), "synced flag dropped")

endmodule

@@ test/clock_sync_interval_estimator_top_test.sv @@
// Self-checking testbench for clock_sync_interval_estimator_top: directed and
// random sync/query requests against a cycle-free predictor of the estimator.
// Depends on csie_pkg and the estimator RTL; nothing else.
`timescale 1ns / 100ps

module clock_sync_interval_estimator_top_test import csie_pkg::*;;

  localparam logic STATUS_VALID = 1'b1;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned RANDOM_TARGET = 1200;
  localparam int unsigned DRAIN_CYCLES = 60;

  typedef struct packed {
    logic               kind;
    logic [30:0]        local_now;
    logic [30:0]        request_sent;
    logic signed [31:0] global_reply;
  } sync_request_t;

  typedef struct packed {
    logic               status;
    logic [29:0]        half_lag;
    logic signed [23:0] drift_q16;
    logic signed [31:0] global_estimate;
  } estimate_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic               kind_i = 1'b0;
  logic [30:0]        local_now_i = '0;
  logic [30:0]        request_sent_i = '0;
  logic signed [31:0] global_reply_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               status_o;
  logic [29:0]        half_lag_o;
  logic signed [23:0] drift_q16_o;
  logic signed [31:0] global_estimate_o;

  clock_sync_interval_estimator_top uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .kind_i           (kind_i),
    .local_now_i      (local_now_i),
    .request_sent_i   (request_sent_i),
    .global_reply_i   (global_reply_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .half_lag_o       (half_lag_o),
    .drift_q16_o      (drift_q16_o),
    .global_estimate_o(global_estimate_o)
  );

  always #5 clk_i = ~clk_i;

  sync_request_t pending_requests[$];
  estimate_t     expected_estimates[$];
  int unsigned   mismatches = 0;
  int unsigned   cycle_count = 0;
  bit            stimulus_built = 1'b0;

  // predictor state
  bit          synced_q = 1'b0;
  logic [31:0] elapsed_q = '0;
  logic [31:0] shift_q = '0;
  logic [31:0] last_local_q = '0;
  logic [31:0] low_q = '0;
  logic [31:0] high_q = '0;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  function automatic logic [31:0] half_toward_zero(input logic [31:0] a, input logic [31:0] b);
    logic signed [31:0] diff;
    longint             wide;
    diff = a - b;
    wide = longint'(diff);
    wide = wide / 2;
    return wide[31:0];
  endfunction

  function automatic logic [23:0] drift_ratio();
    logic signed [31:0] sh32;
    logic signed [31:0] el32;
    longint             sh;
    longint             el;
    longint             q;
    sh32 = shift_q;
    el32 = elapsed_q;
    sh = longint'(sh32);
    el = longint'(el32);
    if (sh == 0 || el <= 0) return '0;
    q = (sh * 65536) / el;
    if (q > 64'sd8388607) q = 64'sd8388607;
    if (q < -64'sd8388608) q = -64'sd8388608;
    return q[23:0];
  endfunction

  function automatic estimate_t advance_estimator(input sync_request_t rq);
    estimate_t   r;
    logic [31:0] now32;
    logic [31:0] req32;
    logic [31:0] glob;
    logic [31:0] lag;
    logic [31:0] top;
    logic [31:0] step;
    logic [31:0] est;
    logic [31:0] mid;
    logic [31:0] half;
    r = '0;
    now32 = {1'b0, rq.local_now};
    req32 = {1'b0, rq.request_sent};
    glob = rq.global_reply;
    if (rq.kind == KindQuery) begin
      if (synced_q) begin
        half = half_toward_zero(high_q, low_q);
        r.status = STATUS_VALID;
        r.half_lag = half[31] ? '0 : half[29:0];
        r.global_estimate = low_q + half + (now32 - last_local_q);
      end
      return r;
    end
    if (now32 < req32) return r;
    lag = now32 - req32;
    top = glob + lag;
    step = now32 - last_local_q;
    if (!synced_q || step[31]) begin
      synced_q = 1'b1;
      elapsed_q = '0;
      shift_q = '0;
      last_local_q = now32;
      low_q = glob;
      high_q = top;
    end else begin
      est = glob + (lag >> 1);
      low_q = low_q + step;
      high_q = high_q + step;
      mid = low_q + half_toward_zero(high_q, low_q);
      elapsed_q = elapsed_q + step;
      shift_q = shift_q + (est - mid);
      last_local_q = now32;
      if ($signed(est) < $signed(low_q) || $signed(est) > $signed(high_q)) begin
        low_q = glob;
        high_q = top;
      end else begin
        if ($signed(glob) > $signed(low_q)) low_q = glob;
        if ($signed(top) < $signed(high_q)) high_q = top;
      end
    end
    r.status = STATUS_VALID;
    r.half_lag = lag[30:1];
    r.drift_q16 = drift_ratio();
    return r;
  endfunction

  task automatic add_request(input logic kind, input logic [30:0] now, input logic [30:0] sent,
                             input logic [31:0] glob);
    sync_request_t rq;
    rq.kind = kind;
    rq.local_now = now;
    rq.request_sent = sent;
    rq.global_reply = glob;
    pending_requests.push_back(rq);
  endtask

  // stimulus
  initial begin : build_stimulus
    logic [30:0] t;
    logic [31:0] truth;
    logic [31:0] lag;
    logic [31:0] dt;
    logic [31:0] glob;
    int unsigned rate_shift;
    int unsigned rate_neg;
    int unsigned seq_len;
    int unsigned pick;
    int unsigned random_count;

    add_request(KindQuery, 31'd500, 31'd0, 32'd0);
    add_request(KindSync, 31'd5, 31'd6, 32'd77);
    add_request(KindSync, 31'd0, 31'h7FFFFFFF, 32'h7FFFFFFF);
    add_request(KindSync, 31'd1000, 31'd900, 32'd50000);
    add_request(KindQuery, 31'd1000, 31'd0, 32'd0);
    add_request(KindSync, 31'd2000, 31'd1990, 32'd51010);
    add_request(KindSync, 31'd3000, 31'd2990, 32'd900000);
    add_request(KindQuery, 31'd3500, 31'h7FFFFFFF, 32'hFFFFFFFF);
    add_request(KindSync, 31'd100, 31'd50, 32'hFFFFFFFB);
    add_request(KindSync, 31'h7FFFFFFF, 31'd0, 32'h7FFFFFFF);
    add_request(KindQuery, 31'h7FFFFFFF, 31'd0, 32'd0);
    add_request(KindSync, 31'd0, 31'd0, 32'h80000000);
    add_request(KindQuery, 31'd0, 31'd0, 32'd0);
    add_request(KindSync, 31'd10, 31'd10, 32'h80000000);
    add_request(KindSync, 31'd20, 31'd10, 32'h7FFFFFF0);
    add_request(KindSync, 31'd30, 31'd25, 32'h80000100);
    add_request(KindQuery, 31'd40, 31'd0, 32'd0);
    add_request(KindSync, 31'h40000000, 31'h3FFFFF00, 32'h7FFFFF00);
    add_request(KindSync, 31'h40000000, 31'h3FFFFE02, 32'h7FFFFF00);
    add_request(KindQuery, 31'h40000010, 31'd0, 32'd0);
    add_request(KindSync, 31'h40000020, 31'h40000021, 32'd0);

    random_count = 0;
    while (random_count < RANDOM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        add_request(1'($urandom_range(0, 1)), 31'($urandom), 31'($urandom), $urandom);
        random_count++;
      end else begin
        t = (pick < 20) ? 31'h7FFF0000 + 31'($urandom_range(0, 16'hFFFF)) : 31'($urandom);
        truth = $urandom;
        rate_shift = $urandom_range(3, 16);
        rate_neg = $urandom_range(0, 1);
        seq_len = $urandom_range(4, 24);
        for (int unsigned i = 0; i < seq_len; i++) begin
          dt = $urandom_range(1, 1 << $urandom_range(0, 16));
          t = t + dt[30:0];
          truth = rate_neg ? truth + dt - (dt >> rate_shift) : truth + dt + (dt >> rate_shift);
          pick = $urandom_range(0, 99);
          if (pick < 30) begin
            add_request(KindQuery, t, 31'($urandom), $urandom);
          end else if (pick < 35) begin
            add_request(KindSync, t, t + 31'($urandom_range(1, 100)), $urandom);
          end else if (pick < 38) begin
            t = t - 31'($urandom_range(1, 1 << 20));
            add_request(KindSync, t, t - 31'($urandom_range(0, 50)), truth);
          end else begin
            lag = (pick < 43) ? $urandom_range(0, 32'h7FFFFFFF) : $urandom_range(0, 4000);
            if (lag > {1'b0, t}) lag = {1'b0, t};
            glob = truth - $urandom_range(0, lag);
            if (pick > 95) glob = glob + $urandom_range(0, 32'h00FFFFFF);
            add_request(KindSync, t, t - lag[30:0], glob);
          end
          random_count++;
        end
      end
    end
    stimulus_built = 1'b1;
  end

  // reset
  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // driver: bursts of requests separated by random gaps
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(posedge clk_i) begin : drive_requests
    logic hold;
    logic next_valid;
    hold = in_valid_i;
    next_valid = in_valid_i;
    if (rst_ni && stimulus_built) begin
      if (in_valid_i && !in_stall_o) begin
        expected_estimates.push_back(advance_estimator(pending_requests.pop_front()));
        hold = 1'b0;
        next_valid = 1'b0;
      end
      if (!hold) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_requests.size() > 0) begin
          kind_i <= pending_requests[0].kind;
          local_now_i <= pending_requests[0].local_now;
          request_sent_i <= pending_requests[0].request_sent;
          global_reply_i <= pending_requests[0].global_reply;
          next_valid = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
          end
        end
      end
      in_valid_i <= next_valid;
    end
  end

  // monitor: compare each accepted result, then pick the next stall value
  logic [1:0] stall_mode = 2'd0;

  always @(posedge clk_i) begin : check_results
    estimate_t want;
    logic      next_stall;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("clock_sync_interval_estimator_top_test NOT OK");
      $finish;
    end else if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_estimates.size() == 0) begin
          report_mismatch("unrequested result", 1, 0);
        end else begin
          want = expected_estimates.pop_front();
          if (status_o !== want.status)
            report_mismatch("status", status_o, want.status);
          if (half_lag_o !== want.half_lag)
            report_mismatch("half_lag", half_lag_o, want.half_lag);
          if (drift_q16_o !== want.drift_q16)
            report_mismatch("drift_q16", drift_q16_o, want.drift_q16);
          if (global_estimate_o !== want.global_estimate)
            report_mismatch("global_estimate", global_estimate_o, want.global_estimate);
        end
      end
      if (cycle_count[5:0] == 6'd0) stall_mode = 2'($urandom_range(0, 3));
      case (stall_mode)
        2'd0: next_stall = 1'b0;
        2'd1: next_stall = ($urandom_range(0, 2) == 0);
        2'd2: next_stall = (cycle_count[2:0] < 3'd5);
        default: next_stall = cycle_count[4];
      endcase
      out_stall_i <= next_stall;
    end
  end

  // end of run
  initial begin
    wait (stimulus_built);
    @(posedge clk_i);
    while (pending_requests.size() > 0 || expected_estimates.size() > 0 || in_valid_i)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && expected_estimates.size() == 0) begin
      $display("clock_sync_interval_estimator_top_test OK");
    end else begin
      $display("clock_sync_interval_estimator_top_test NOT OK");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+sv
sv/csie_pkg.sv
sv/csie_drift_div.sv
sv/clock_sync_interval_estimator_top.sv
test/clock_sync_interval_estimator_top_test.sv
